// ===== sv/dual_box_downscale_2x2_unit_assert.svh =====
// Assertion macros shared by the downscaler RTL.
`ifndef DUAL_BOX_DOWNSCALE_2X2_UNIT_ASSERT_SVH
`define DUAL_BOX_DOWNSCALE_2X2_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and quiet during reset.
`define DBDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet during reset.
`define DBDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dbds_pkg.sv =====
// Types and constants of the dual-camera 2x2 box downscaler.
`timescale 1ns / 1ps

package dbds_pkg;

    // Configuration register layout.
    localparam int CFG_DATA_W = 12;
    localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;
    localparam logic [CFG_DATA_W-1:0] CFG_WIDTH_RST  = 12'd1920;
    localparam logic [CFG_DATA_W-1:0] CFG_HEIGHT_RST = 12'd1080;

    // Default size limits.
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;

    // Channel, line-buffer and output coordinate field widths.
    localparam int PIX_W  = 8;
    localparam int PAIR_W = 9;
    localparam int OUT_X_W = 11;
    localparam int OUT_Y_W = 10;

    // One source pixel.
    typedef struct packed {
        logic             camera;
        logic             frame_start;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pix_in;

    // One downscaled destination pixel.
    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic [PIX_W-1:0]   out_red;
        logic [PIX_W-1:0]   out_green;
        logic [PIX_W-1:0]   out_blue;
    } t_pix_out;

    // Horizontal pair sums kept in the line buffer.
    typedef struct packed {
        logic [PAIR_W-1:0] blue;
        logic [PAIR_W-1:0] green;
        logic [PAIR_W-1:0] red;
    } t_pair_sum;

endpackage

// ===== sv/dual_box_downscale_2x2_unit.sv =====
// Dual-camera 2x2 box-filter downscaler, top level.
//
// Source pixels of camera 0 or 1 enter in raster order on i_valid/o_stall as one
// transaction per pixel; frame_start on a pixel restarts the column and row count.
// Each 2x2 block of a frame becomes one averaged pixel on o_valid/i_stall, placed
// in the left half for camera 0 and the right half for camera 1.
// Frame width and height are set through i_cfg_we/i_cfg_idx/i_cfg_wdata while idle.
// Throughput is one pixel per cycle unless o_stall is raised: the line buffer is a
// single-port memory and each pixel needs at most one access to it (write on even rows, read on odd rows).
// The result of a completing pixel is registered first in the read stage, together
// with the line buffer read, and then in the output register.
// When the receiver stalls, the output register holds its transaction and one more
// result may wait in the read stage; once both are full, o_stall is raised for every
// pixel until the receiver takes the output.
// Reset clears the counters, the pipeline valids and restores the default frame
// size. The line buffer is not cleared; every entry is written on an even row
// before the odd row reads it, so no clearing pass is needed.
`timescale 1ns / 1ps

module dual_box_downscale_2x2_unit #(
    parameter int MAX_WIDTH  = dbds_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = dbds_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [0:0]                        i_cfg_idx,
    input  logic [dbds_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  dbds_pkg::t_pix_in                 i_data,
    output logic                              o_valid,
    input  logic                              i_stall,
    output dbds_pkg::t_pix_out                o_data
);

    import dbds_pkg::*;

    // Derived widths.
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int LW = $clog2(LINE_DEPTH);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT + 1);
    localparam int CWW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CWW > CFG_DATA_W) ? CWW : CFG_DATA_W;
    localparam int HW = (YW > CFG_DATA_W) ? YW : CFG_DATA_W;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_cfg_w;
    logic [CFG_DATA_W-1:0] r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_WIDTH_RST;
            r_cfg_h <= CFG_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IDX_WIDTH:  r_cfg_w <= i_cfg_wdata;
                CFG_IDX_HEIGHT: r_cfg_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective frame size, capped at the build limits.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    assign w_eff = (WW'(r_cfg_w) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(r_cfg_w);
    assign h_eff = (HW'(r_cfg_h) > HW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(r_cfg_h);

    // Pipeline registers.
    logic [XW-1:0]      r_col;
    logic [YW-1:0]      r_row;
    logic [3*PIX_W-1:0] r_held;
    logic               r_s1_vld;
    logic [OUT_X_W-1:0] r_s1_x;
    logic [OUT_Y_W-1:0] r_s1_y;
    t_pair_sum          r_s1_sum;
    logic               r_out_vld;
    t_pix_out           r_out;
    t_pair_sum          r_mem_q;

    // Flow control: the output register frees when taken, the read stage when it
    // moves on; a pixel is held back only while the read stage cannot move.
    logic out_free;
    logic s1_adv;
    logic acc;

    assign out_free = !r_out_vld || !i_stall;
    assign s1_adv   = !r_s1_vld || out_free;
    assign o_stall  = !s1_adv;
    assign acc      = i_valid && !o_stall;

    // Position of the incoming pixel and what it does.
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          in_frame;
    logic          is_write;
    logic          is_read;
    logic [WW-1:0] x_inc;
    logic [LW-1:0] line_idx;
    t_pair_sum     pair;

    assign x        = i_data.frame_start ? '0 : r_col;
    assign y        = i_data.frame_start ? '0 : r_row;
    assign in_frame = (WW'(x) < w_eff) && (HW'(y) < h_eff);
    assign is_write = acc && in_frame && x[0] && !y[0];
    assign is_read  = acc && in_frame && x[0] && y[0];
    assign x_inc    = WW'(x) + WW'(1);
    assign line_idx = x[LW:1];

    assign pair.red   = PAIR_W'(r_held[PIX_W-1:0])         + PAIR_W'(i_data.red);
    assign pair.green = PAIR_W'(r_held[2*PIX_W-1:PIX_W])   + PAIR_W'(i_data.green);
    assign pair.blue  = PAIR_W'(r_held[3*PIX_W-1:2*PIX_W]) + PAIR_W'(i_data.blue);

    // Column and row counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (!in_frame) begin
                r_col <= x;
                r_row <= y;
            end else if (x_inc >= w_eff) begin
                r_col <= '0;
                r_row <= y + YW'(1);
            end else begin
                r_col <= x_inc[XW-1:0];
                r_row <= y;
            end
        end
    end

    // Pixel of the last even column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (acc && in_frame && !x[0]) begin
            r_held <= {i_data.blue, i_data.green, i_data.red};
        end
    end

    // Line buffer of pair sums: one access per pixel, read data registered.
    t_pair_sum line_mem [LINE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (is_write) begin
            line_mem[line_idx] <= pair;
        end
        if (is_read) begin
            r_mem_q <= line_mem[line_idx];
        end
    end

    // Read stage: holds the completing pixel's pair sum and position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s1_vld <= is_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_read) begin
            r_s1_x   <= OUT_X_W'(WW'(x >> 1) + (i_data.camera ? (w_eff >> 1) : '0));
            r_s1_y   <= OUT_Y_W'(y >> 1);
            r_s1_sum <= pair;
        end
    end

    // Block sums and truncated average.
    logic [PAIR_W:0] sum_r;
    logic [PAIR_W:0] sum_g;
    logic [PAIR_W:0] sum_b;

    assign sum_r = (PAIR_W+1)'(r_s1_sum.red)   + (PAIR_W+1)'(r_mem_q.red);
    assign sum_g = (PAIR_W+1)'(r_s1_sum.green) + (PAIR_W+1)'(r_mem_q.green);
    assign sum_b = (PAIR_W+1)'(r_s1_sum.blue)  + (PAIR_W+1)'(r_mem_q.blue);

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_vld) begin
            r_out.out_x     <= r_s1_x;
            r_out.out_y     <= r_s1_y;
            r_out.out_red   <= sum_r[PAIR_W:2];
            r_out.out_green <= sum_g[PAIR_W:2];
            r_out.out_blue  <= sum_b[PAIR_W:2];
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // Checks.
`include "dual_box_downscale_2x2_unit_assert.svh"

    `DBDS_ASSERT_NEXT(a_read_fills_stage, is_read, r_s1_vld, "line read did not fill read stage")
    `DBDS_ASSERT_NOW(a_out_from_stage, $rose(o_valid), $past(r_s1_vld), "result without read stage")
    `DBDS_ASSERT_NEXT(a_col_ok, acc && in_frame, WW'(r_col) < $past(w_eff), "column past width")

endmodule

// ===== tb/dual_box_downscale_2x2_unit_tb.sv =====
// Self-checking testbench of the dual-camera 2x2 box downscaler.
`timescale 1ns / 1ps

module dual_box_downscale_2x2_unit_tb;

    import dbds_pkg::*;

    localparam int LINE_SLOTS = DEF_MAX_WIDTH / 2;
    localparam int IDLE_PCT   = 21;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int RANDOM_PIXELS  = 800;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [0:0]            i_cfg_idx = CFG_IDX_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_pix_in               i_data = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_pix_out              o_data;

    dual_box_downscale_2x2_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

    // Stimulus and expectation stores.
    t_pix_in  pixel_backlog[$];
    t_pix_out due_averages[$];

    // Downscaler state as the testbench predicts it.
    int unsigned frame_w_cfg = CFG_WIDTH_RST;
    int unsigned frame_h_cfg = CFG_HEIGHT_RST;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [PIX_W-1:0] held_r = '0;
    logic [PIX_W-1:0] held_g = '0;
    logic [PIX_W-1:0] held_b = '0;
    t_pair_sum pair_line [LINE_SLOTS];

    // Run control and bookkeeping.
    bit pixel_taken = 1'b0;
    bit steady_flow = 1'b0;
    bit squeeze_req = 1'b0;
    bit squeeze_done = 1'b0;
    int hold_left = 0;
    int errors = 0;
    int pixels_seen = 0;
    int averages_seen = 0;
    int settings_run = 0;
    t_pix_out want;

    // Clock with a 12 ns period.
    always #6 i_clk = ~i_clk;

    // Fold one accepted pixel into the predicted state and queue any average it completes.
    task automatic fold_pixel(input t_pix_in p);
        int unsigned w, h, x, y, ix;
        logic [9:0] sum_r, sum_g, sum_b;
        logic [31:0] dest_x;
        t_pix_out avg;
        w = (frame_w_cfg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : frame_w_cfg;
        h = (frame_h_cfg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : frame_h_cfg;
        if (p.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        if (x >= w || y >= h) return;
        ix = (x / 2) % LINE_SLOTS;
        if (x % 2 == 0) begin
            held_r = p.red;
            held_g = p.green;
            held_b = p.blue;
        end else begin
            sum_r = held_r + p.red;
            sum_g = held_g + p.green;
            sum_b = held_b + p.blue;
            if (y % 2 == 0) begin
                pair_line[ix].red   = sum_r[PAIR_W-1:0];
                pair_line[ix].green = sum_g[PAIR_W-1:0];
                pair_line[ix].blue  = sum_b[PAIR_W-1:0];
            end else begin
                sum_r = sum_r + pair_line[ix].red;
                sum_g = sum_g + pair_line[ix].green;
                sum_b = sum_b + pair_line[ix].blue;
                dest_x = x / 2 + (p.camera ? w / 2 : 0);
                avg.out_x     = dest_x[OUT_X_W-1:0];
                avg.out_y     = 10'(y / 2);
                avg.out_red   = sum_r[9:2];
                avg.out_green = sum_g[9:2];
                avg.out_blue  = sum_b[9:2];
                due_averages.push_back(avg);
            end
        end
        col_pos = x + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = y + 1;
        end
    endtask

    task automatic check_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, exp_val, act_val);
            errors++;
        end
    endtask

    // Input side: predict every pixel transaction at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            fold_pixel(i_data);
            pixels_seen++;
            pixel_taken <= 1'b1;
        end else begin
            pixel_taken <= 1'b0;
        end
    end

    // Pixel driver: offers the next queued pixel once the previous one has gone.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_valid || pixel_taken)) begin
            if (pixel_backlog.size() != 0
                    && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT)) begin
                i_data  <= pixel_backlog.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (squeeze_req && !squeeze_done) begin
            i_stall      <= 1'b1;
            hold_left    <= SQUEEZE_CYCLES;
            squeeze_done <= 1'b1;
        end else begin
            i_stall <= !steady_flow && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Output monitor: each averaged pixel transaction against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_averages.size() == 0) begin
                $display("%0t ns: expected no averaged pixel, got x=%0d y=%0d rgb=%0d,%0d,%0d",
                         $time, o_data.out_x, o_data.out_y, o_data.out_red,
                         o_data.out_green, o_data.out_blue);
                errors++;
            end else begin
                want = due_averages.pop_front();
                check_field("out_x", want.out_x, o_data.out_x);
                check_field("out_y", want.out_y, o_data.out_y);
                check_field("out_red", want.out_red, o_data.out_red);
                check_field("out_green", want.out_green, o_data.out_green);
                check_field("out_blue", want.out_blue, o_data.out_blue);
            end
            averages_seen++;
        end
    end

    // Channel value biased towards the extremes.
    function automatic logic [PIX_W-1:0] pick_level();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return '0;
        if (roll < 20) return '1;
        return PIX_W'($urandom);
    endfunction

    task automatic push_px(input bit cam, input bit fs, input int r, input int g, input int b);
        t_pix_in p;
        p.camera      = cam;
        p.frame_start = fs;
        p.red         = r[PIX_W-1:0];
        p.green       = g[PIX_W-1:0];
        p.blue        = b[PIX_W-1:0];
        pixel_backlog.push_back(p);
    endtask

    // Queue a run of random pixels; a messy run mixes cameras and restarts frames early.
    task automatic queue_pixels(input int n_px, input bit fresh, input bit messy);
        bit cam, fs;
        int k;
        cam = $urandom_range(0, 1);
        for (k = 0; k < n_px; k++) begin
            fs = fresh && k == 0;
            if (messy && k > 0 && $urandom_range(0, 199) == 0) fs = 1'b1;
            push_px((messy && $urandom_range(0, 99) < 4) ? !cam : cam, fs,
                    pick_level(), pick_level(), pick_level());
        end
    endtask

    // Wait until every pixel is in and every average out, then let the pipeline empty.
    task automatic drain();
        do @(posedge i_clk);
        while (pixel_backlog.size() != 0 || i_valid || due_averages.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[CFG_DATA_W-1:0];
        if (idx == CFG_IDX_WIDTH) frame_w_cfg = val;
        else frame_h_cfg = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        settings_run++;
    endtask

    // Run timeout.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Test sequence.
    initial begin
        int unsigned w, h;
        int random_px, frames, f;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Mid-size frame with a long receiver hold-off from its second row on.
        set_size(32, 12);
        queue_pixels(32, 1'b1, 1'b0);
        while (pixel_backlog.size() != 0) @(posedge i_clk);
        squeeze_req = 1'b1;
        queue_pixels(32 * 11, 1'b0, 1'b0);
        drain();

        // Directed frame of 4x3: saturated and zero blocks, camera switch inside a
        // block, an odd last row, pixels past the frame and an early frame restart.
        set_size(4, 3);
        push_px(1, 1, 255, 255, 255);
        push_px(1, 0, 255, 255, 255);
        push_px(0, 0, 0, 0, 0);
        push_px(0, 0, 0, 0, 0);
        push_px(1, 0, 255, 255, 255);
        push_px(1, 0, 255, 255, 255);
        push_px(0, 0, 0, 255, 1);
        push_px(1, 0, 3, 0, 128);
        push_px(0, 0, 17, 34, 51);
        push_px(0, 0, 68, 85, 102);
        push_px(1, 0, 119, 136, 153);
        push_px(1, 0, 170, 187, 204);
        push_px(1, 0, 200, 100, 50);
        push_px(0, 0, 1, 2, 3);
        push_px(0, 1, 128, 64, 32);
        push_px(0, 0, 127, 63, 31);
        push_px(1, 1, 255, 0, 255);
        push_px(1, 0, 255, 0, 255);
        push_px(1, 0, 1, 1, 1);
        push_px(1, 0, 254, 254, 254);
        push_px(0, 0, 255, 0, 255);
        push_px(0, 0, 255, 0, 255);
        push_px(0, 0, 0, 0, 0);
        push_px(0, 0, 3, 3, 3);
        drain();

        // Wide frame at full rate with no idling on either side.
        steady_flow = 1'b1;
        set_size(128, 4);
        queue_pixels(128 * 4, 1'b1, 1'b0);
        drain();
        steady_flow = 1'b0;

        // Random small sizes, odd ones included, with a few untidy frames.
        random_px = 0;
        while (random_px < RANDOM_PIXELS) begin
            w = $urandom_range(2, 40);
            h = $urandom_range(2, 12);
            set_size(w, h);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                queue_pixels(w * h + $urandom_range(0, 3), 1'b1, $urandom_range(0, 2) == 0);
                random_px += w * h;
            end
            drain();
        end

        $display("Covered %0d source pixels and %0d averaged pixels over %0d frame sizes,",
                 pixels_seen, averages_seen, settings_run);
        $display("including odd sizes, early restarts, a full-rate stretch and a long hold-off.");
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
